// ===== rtl/core/cidd_pkg.sv =====
// ----------------------------------------------------------------------------
// cidd_pkg
// Types and constants shared by the caller-ID message deframer modules.
// ----------------------------------------------------------------------------
package cidd_pkg;

  // Event codes on the input channel.
  typedef enum logic [1:0] {
    CMD_CARRIER = 2'd0,
    CMD_DCLK    = 2'd1,
    CMD_DRDY    = 2'd2,
    CMD_ABORT   = 2'd3
  } cmd_t;

  // Framer phase.
  typedef enum logic [1:0] {
    PH_STANDBY = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_BODY    = 2'd2
  } phase_t;

  // Byte kinds on the result channel.
  localparam logic [1:0] KIND_TYPE     = 2'd0;
  localparam logic [1:0] KIND_LENGTH   = 2'd1;
  localparam logic [1:0] KIND_BODY     = 2'd2;
  localparam logic [1:0] KIND_CHECKSUM = 2'd3;

  // Status codes on the result channel.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CSUM_ERR = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MDMF_TYPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SDMF_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOTAL = 2'd2;

  localparam logic [7:0] MDMF_TYPE_RST = 8'd128;
  localparam logic [7:0] SDMF_TYPE_RST = 8'd4;
  localparam logic [7:0] MAX_TOTAL_RST = 8'd255;

  // Framing limits: shortest legal length, and header plus checksum bytes.
  localparam logic [7:0] MIN_LENGTH  = 8'd2;
  localparam logic [8:0] FRAME_EXTRA = 9'd3;

  typedef struct packed {
    cmd_t cmd;
    logic data_bit;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       last_byte;
    logic [1:0] status;
  } result_t;

  // Handshake between the input register and the framer.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// ===== rtl/core/cidd_if.sv =====
// ----------------------------------------------------------------------------
// cidd_if
// Valid/ready channels for decoder events and deframed bytes.
// ----------------------------------------------------------------------------
interface cidd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       data_bit;

  modport source (output valid, output cmd, output data_bit, input ready);
  modport sink (input valid, input cmd, input data_bit, output ready);
endinterface

interface cidd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       last_byte;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_kind, output last_byte,
                  output status, input ready);
  modport sink (input valid, input out_byte, input byte_kind, input last_byte,
                input status, output ready);
endinterface

// ===== rtl/core/cidd_in_stage.sv =====
// ----------------------------------------------------------------------------
// cidd_in_stage
// Input register holding one decoder event until the framer takes it.
// ----------------------------------------------------------------------------
module cidd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cidd_pkg::item_t in_item,
  input  logic           take,
  output cidd_pkg::stage_t stage
);
  import cidd_pkg::*;

  logic  vld;
  item_t item;

  assign in_ready = !vld || take;
  assign stage    = '{valid: vld, item: item};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/core/cidd_framer.sv =====
// ----------------------------------------------------------------------------
// cidd_framer
// Bit assembly, framing state and configuration registers; computes at most
// one result per event.
// ----------------------------------------------------------------------------
module cidd_framer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cidd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              step,
  input  cidd_pkg::item_t                   item,
  output logic                              res_vld,
  output cidd_pkg::result_t                 res
);
  import cidd_pkg::*;

  logic [7:0] mdmf_type;
  logic [7:0] sdmf_type;
  logic [7:0] max_total;

  logic [7:0] shift_byte, shift_byte_next;
  logic       armed, armed_next;
  phase_t     phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;

  logic [7:0] sum_add;
  logic [8:0] len_total;

  assign sum_add   = running_sum + shift_byte;
  assign len_total = {1'b0, shift_byte} + FRAME_EXTRA;

  always_comb begin
    shift_byte_next  = shift_byte;
    armed_next       = armed;
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    res_vld          = 1'b0;
    res              = '{out_byte: shift_byte, byte_kind: KIND_TYPE, last_byte: 1'b0,
                         status: ST_OK};
    unique case (item.cmd)
      CMD_CARRIER: begin
        phase_next      = PH_STANDBY;
        shift_byte_next = '0;
        armed_next      = 1'b1;
      end
      CMD_DCLK: begin
        if (armed) begin
          shift_byte_next = {item.data_bit, shift_byte[7:1]};
        end
      end
      CMD_DRDY: begin
        shift_byte_next = '0;
        unique case (phase)
          PH_STANDBY: begin
            if (shift_byte == mdmf_type || shift_byte == sdmf_type) begin
              running_sum_next = shift_byte;
              phase_next       = PH_LENGTH;
              res_vld          = 1'b1;
            end
          end
          PH_LENGTH: begin
            res_vld       = 1'b1;
            res.byte_kind = KIND_LENGTH;
            if (shift_byte < MIN_LENGTH || len_total > {1'b0, max_total}) begin
              phase_next    = PH_STANDBY;
              res.last_byte = 1'b1;
              res.status    = ST_BAD_LEN;
            end else begin
              running_sum_next = sum_add;
              bytes_left_next  = shift_byte + 8'd1;
              phase_next       = PH_BODY;
            end
          end
          PH_BODY: begin
            res_vld          = 1'b1;
            running_sum_next = sum_add;
            if (bytes_left <= 8'd1) begin
              // Checksum byte: the whole message must sum to zero.
              bytes_left_next = '0;
              phase_next      = PH_STANDBY;
              res.byte_kind   = KIND_CHECKSUM;
              res.last_byte   = 1'b1;
              res.status      = (sum_add != 8'd0) ? ST_CSUM_ERR : ST_OK;
            end else begin
              bytes_left_next = bytes_left - 8'd1;
              res.byte_kind   = KIND_BODY;
            end
          end
          default: begin
            phase_next = PH_STANDBY;
          end
        endcase
      end
      CMD_ABORT: begin
        phase_next       = PH_STANDBY;
        shift_byte_next  = '0;
        armed_next       = 1'b0;
        bytes_left_next  = '0;
        running_sum_next = '0;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte  <= '0;
      armed       <= 1'b0;
      phase       <= PH_STANDBY;
      bytes_left  <= '0;
      running_sum <= '0;
    end else if (step) begin
      shift_byte  <= shift_byte_next;
      armed       <= armed_next;
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mdmf_type <= MDMF_TYPE_RST;
      sdmf_type <= SDMF_TYPE_RST;
      max_total <= MAX_TOTAL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MDMF_TYPE: mdmf_type <= cfg_data;
        CFG_SDMF_TYPE: sdmf_type <= cfg_data;
        CFG_MAX_TOTAL: max_total <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/cidd_out_reg.sv =====
// ----------------------------------------------------------------------------
// cidd_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module cidd_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              res_vld,
  input  cidd_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output cidd_pkg::result_t out_res,
  output logic              can_load
);
  import cidd_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_vld;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      out_res <= res;
    end
  end

endmodule

// ===== rtl/core/caller_id_message_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// caller_id_message_deframer_unit
// Caller-ID (SDMF/MDMF) deframer fed by bit-serial decoder events.
// ----------------------------------------------------------------------------
// Each event (carrier detect, data clock, data ready, abort) is taken into an
// input register and processed once the result register is free or being
// drained; the framer then updates its state and loads the result register,
// which presents the result on the output. One event is taken per clock as
// long as the result register is free or being drained, so the sustained rate
// is one event per cycle. Events that produce no byte simply pass through
// without occupying the result register.
// Configuration writes are only allowed while no event is in flight.
// ----------------------------------------------------------------------------
module caller_id_message_deframer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [cidd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  cidd_in_if.sink                        din,
  cidd_out_if.source                     dout
);
  import cidd_pkg::*;

  item_t   in_item;
  stage_t  stage;
  logic    step;
  logic    can_load;
  logic    res_vld;
  result_t res;
  result_t out_res;

  assign in_item = '{cmd: cmd_t'(din.cmd), data_bit: din.data_bit};
  assign step    = stage.valid && can_load;

  cidd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (din.ready),
    .in_item  (in_item),
    .take     (step),
    .stage    (stage)
  );

  cidd_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .item      (stage.item),
    .res_vld   (res_vld),
    .res       (res)
  );

  cidd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_vld   (res_vld),
    .res       (res),
    .out_ready (dout.ready),
    .out_valid (dout.valid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign dout.out_byte  = out_res.out_byte;
  assign dout.byte_kind = out_res.byte_kind;
  assign dout.last_byte = out_res.last_byte;
  assign dout.status    = out_res.status;

endmodule

// ===== test/caller_id_message_deframer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// caller_id_message_deframer_unit_tb
// Self-checking bench for the caller-ID deframer. A short table of directed
// events is followed by randomized caller-ID messages under several register
// settings. Each event transfer goes through a cycle-free model of the framer,
// and every byte transfer is compared field by field with the oldest
// predicted byte. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module caller_id_message_deframer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cidd_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 6;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 3000;

  typedef struct packed {
    cmd_t    cmd;
    logic    data_bit;
    logic    typed;
    result_t want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t TYPE_80   = '{8'h80, KIND_TYPE, 1'b0, ST_OK};
  localparam result_t BODY_00   = '{8'h00, KIND_BODY, 1'b0, ST_OK};

  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_DCLK,    1'b1, 1'b0, NO_RESULT},
    '{CMD_DRDY,    1'b1, 1'b0, NO_RESULT},
    '{CMD_CARRIER, 1'b0, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b1, 1'b0, NO_RESULT},
    '{CMD_DRDY,    1'b0, 1'b1, TYPE_80},
    '{CMD_DRDY,    1'b1, 1'b1, '{8'h00, KIND_LENGTH, 1'b1, ST_BAD_LEN}},
    '{CMD_DCLK,    1'b1, 1'b0, NO_RESULT},
    '{CMD_DRDY,    1'b0, 1'b1, TYPE_80},
    '{CMD_DCLK,    1'b1, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b0, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b0, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b0, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b0, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b0, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b0, 1'b0, NO_RESULT},
    '{CMD_DRDY,    1'b1, 1'b1, '{8'h02, KIND_LENGTH, 1'b0, ST_OK}},
    '{CMD_DRDY,    1'b0, 1'b1, BODY_00},
    '{CMD_DRDY,    1'b1, 1'b1, BODY_00},
    '{CMD_DRDY,    1'b0, 1'b1, '{8'h00, KIND_CHECKSUM, 1'b1, ST_CSUM_ERR}},
    '{CMD_DCLK,    1'b1, 1'b0, NO_RESULT},
    '{CMD_DRDY,    1'b1, 1'b1, TYPE_80},
    '{CMD_CARRIER, 1'b1, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b1, 1'b0, NO_RESULT},
    '{CMD_DRDY,    1'b0, 1'b1, TYPE_80},
    '{CMD_ABORT,   1'b1, 1'b0, NO_RESULT},
    '{CMD_DCLK,    1'b1, 1'b0, NO_RESULT},
    '{CMD_DRDY,    1'b0, 1'b0, NO_RESULT}
  };

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  cidd_in_if  ev_ch ();
  cidd_out_if byte_ch ();

  caller_id_message_deframer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .din       (ev_ch),
    .dout      (byte_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Framer model state and its copy of the registers.
  logic [7:0] mdmf_code = MDMF_TYPE_RST;
  logic [7:0] sdmf_code = SDMF_TYPE_RST;
  logic [7:0] max_total = MAX_TOTAL_RST;
  logic [7:0] fr_shift  = '0;
  logic       fr_armed  = 1'b0;
  phase_t     fr_phase  = PH_STANDBY;
  logic [7:0] fr_type   = '0;
  logic [7:0] fr_left   = '0;
  logic [7:0] fr_sum    = '0;

  result_t pending_bytes [$];
  int      mismatches    = 0;
  int      events_taken  = 0;
  int      quiet_cycles  = 0;
  bit      send_idle     = 1'b0;
  bit      stall_enable  = 1'b0;
  bit      calm          = 1'b0;
  bit      long_hold_req = 1'b0;

  function automatic bit deframe_event(input cmd_t c, input logic b, output result_t r);
    logic [7:0] v;
    bit         got;
    got = 1'b0;
    r   = '0;
    case (c)
      CMD_CARRIER: begin
        fr_phase = PH_STANDBY;
        fr_shift = '0;
        fr_armed = 1'b1;
      end
      CMD_DCLK: begin
        if (fr_armed) fr_shift = {b, fr_shift[7:1]};
      end
      CMD_DRDY: begin
        v        = fr_shift;
        fr_shift = '0;
        case (fr_phase)
          PH_STANDBY: begin
            if (v == mdmf_code || v == sdmf_code) begin
              fr_type  = v;
              fr_sum   = v;
              fr_phase = PH_LENGTH;
              r        = '{v, KIND_TYPE, 1'b0, ST_OK};
              got      = 1'b1;
            end
          end
          PH_LENGTH: begin
            got = 1'b1;
            if (v < MIN_LENGTH || ({1'b0, v} + FRAME_EXTRA) > {1'b0, max_total}) begin
              fr_phase = PH_STANDBY;
              r        = '{v, KIND_LENGTH, 1'b1, ST_BAD_LEN};
            end else begin
              fr_sum   = fr_sum + v;
              fr_left  = v + 8'd1;
              fr_phase = PH_BODY;
              r        = '{v, KIND_LENGTH, 1'b0, ST_OK};
            end
          end
          PH_BODY: begin
            got    = 1'b1;
            fr_sum = fr_sum + v;
            if (fr_left <= 8'd1) begin
              fr_left  = '0;
              fr_phase = PH_STANDBY;
              r = '{v, KIND_CHECKSUM, 1'b1, (fr_sum != 8'd0) ? ST_CSUM_ERR : ST_OK};
            end else begin
              fr_left = fr_left - 8'd1;
              r       = '{v, KIND_BODY, 1'b0, ST_OK};
            end
          end
          default: fr_phase = PH_STANDBY;
        endcase
      end
      default: begin
        fr_phase = PH_STANDBY;
        fr_shift = '0;
        fr_armed = 1'b0;
        fr_left  = '0;
        fr_sum   = '0;
      end
    endcase
    return got;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Offers one event and runs the model once the transfer has happened. A
  // typed row supplies its own expected byte in place of the model's.
  task automatic send_event(cmd_t c, logic b, logic typed = 1'b0, result_t want = '0);
    result_t pred;
    bit      has;
    if (send_idle && $urandom_range(0, 7) == 0) begin
      ev_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    ev_ch.valid    <= 1'b1;
    ev_ch.cmd      <= c;
    ev_ch.data_bit <= b;
    @(posedge clk);
    while (!ev_ch.ready) @(posedge clk);
    has = deframe_event(c, b, pred);
    if (typed) pending_bytes.push_back(want);
    else if (has) pending_bytes.push_back(pred);
    events_taken++;
  endtask

  task automatic send_byte(logic [7:0] v);
    for (int i = 0; i < 8; i++) send_event(CMD_DCLK, v[i]);
    send_event(CMD_DRDY, 1'($urandom_range(0, 1)));
  endtask

  // One message, mostly well formed: carrier, type, length, body, checksum.
  // Some carry a bad length, a wrong checksum, or stop halfway.
  task automatic send_message();
    int         max_len;
    int         len;
    int         n_body;
    int         pick;
    logic [7:0] type_code;
    logic [7:0] sum;
    logic [7:0] v;
    max_len = int'(max_total) - 3;
    if ($urandom_range(0, 9) != 0) send_event(CMD_CARRIER, 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: type_code = mdmf_code;
      5, 6, 7, 8:    type_code = sdmf_code;
      default:       type_code = 8'($urandom_range(0, 255));
    endcase
    send_byte(type_code);
    sum  = type_code;
    pick = $urandom_range(0, 9);
    if (max_len < 2 || pick == 8) begin
      case ($urandom_range(0, 3))
        0:       len = 0;
        1:       len = 1;
        2:       len = (max_len + 1 > 255) ? 255 : ((max_len + 1 < 0) ? 0 : max_len + 1);
        default: len = $urandom_range(0, 255);
      endcase
      send_byte(8'(len));
      return;
    end
    if (pick == 9) len = $urandom_range(2, max_len);
    else if (pick == 7) len = (max_len <= 40) ? max_len : $urandom_range(2, 12);
    else len = $urandom_range(2, (max_len < 12) ? max_len : 12);
    send_byte(8'(len));
    sum    = sum + 8'(len);
    n_body = (pick == 9) ? $urandom_range(0, (len < 6) ? len - 1 : 5) : len;
    for (int i = 0; i < n_body; i++) begin
      v   = 8'($urandom_range(0, 255));
      sum = sum + v;
      send_byte(v);
    end
    if (pick == 9) begin
      send_event(($urandom_range(0, 1) != 0) ? CMD_ABORT : CMD_CARRIER,
                 1'($urandom_range(0, 1)));
      return;
    end
    v = 8'd0 - sum;
    if ($urandom_range(0, 4) == 0) v = 8'($urandom_range(0, 255));
    send_byte(v);
  endtask

  task automatic run_random(int budget);
    int start;
    start = events_taken;
    while (events_taken - start < budget) begin
      send_idle    = !calm && ($urandom_range(0, 3) != 0);
      stall_enable = !calm && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          send_event(cmd_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      end else begin
        send_message();
      end
    end
  endtask

  // Also used at the end: lets the pipeline empty out before anything else.
  task automatic wait_for_drain();
    ev_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(logic [7:0] mdmf, logic [7:0] sdmf, logic [7:0] max_bytes);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [7:0]           vals [3];
    idx  = '{CFG_MDMF_TYPE, CFG_SDMF_TYPE, CFG_MAX_TOTAL};
    vals = '{mdmf, sdmf, max_bytes};
    for (int i = 0; i < 3; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    mdmf_code = mdmf;
    sdmf_code = sdmf;
    max_total = max_bytes;
  endtask

  initial begin : stimulus
    logic [7:0] code;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_index      = CFG_MDMF_TYPE;
    cfg_data       = '0;
    ev_ch.valid    = 1'b0;
    ev_ch.cmd      = CMD_CARRIER;
    ev_ch.data_bit = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle    = 1'b1;
    stall_enable = 1'b1;
    foreach (DIRECTED[i])
      send_event(DIRECTED[i].cmd, DIRECTED[i].data_bit, DIRECTED[i].typed, DIRECTED[i].want);
    run_random(300);

    wait_for_drain();
    apply_config(8'h00, 8'hFF, 8'd5);
    run_random(200);

    // The receiver holds off for a long stretch while messages keep coming.
    wait_for_drain();
    apply_config(8'hFF, 8'h00, 8'd255);
    long_hold_req = 1'b1;
    run_random(250);

    // Below the smallest useful size every length is rejected.
    wait_for_drain();
    apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd4);
    run_random(100);

    repeat (3) begin
      wait_for_drain();
      code = 8'($urandom_range(0, 255));
      apply_config(code, ($urandom_range(0, 3) == 0) ? code : 8'($urandom_range(0, 255)),
                   8'($urandom_range(5, 40)));
      run_random(150);
    end

    wait_for_drain();
    apply_config(MDMF_TYPE_RST, SDMF_TYPE_RST, MAX_TOTAL_RST);
    calm         = 1'b1;
    send_idle    = 1'b0;
    stall_enable = 1'b0;
    run_random(200);

    wait_for_drain();
    if (mismatches == 0) begin
      $display("caller_id_message_deframer_unit test passed");
    end else begin
      $display("caller_id_message_deframer_unit test failed");
    end
    $finish;
  end

  initial begin : drain_side
    int unsigned n;
    byte_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        byte_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (stall_enable && $urandom_range(0, 5) == 0) begin
        byte_ch.ready <= 1'b0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        byte_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : byte_checker
    result_t want;
    if (!rst && byte_ch.valid && byte_ch.ready) begin
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %0h kind %0d", byte_ch.out_byte,
                                  byte_ch.byte_kind));
      end else begin
        want = pending_bytes.pop_front();
        check_field("out_byte", byte_ch.out_byte, want.out_byte);
        check_field("byte_kind", 8'(byte_ch.byte_kind), 8'(want.byte_kind));
        check_field("last_byte", 8'(byte_ch.last_byte), 8'(want.last_byte));
        check_field("status", 8'(byte_ch.status), 8'(want.status));
      end
    end
  end

  // Ends the run when neither channel has seen a transfer for too long.
  always @(posedge clk) begin : watchdog
    if ((ev_ch.valid && ev_ch.ready) || (byte_ch.valid && byte_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("caller_id_message_deframer_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
rtl/core/cidd_pkg.sv
rtl/core/cidd_if.sv
rtl/core/cidd_in_stage.sv
rtl/core/cidd_framer.sv
rtl/core/cidd_out_reg.sv
rtl/core/caller_id_message_deframer_unit.sv
test/caller_id_message_deframer_unit_tb.sv
